FILE: src/wildcard_name_matcher_unit_macros.svh
// assertion macros used by the wildcard name matcher top level
`ifndef WILDCARD_NAME_MATCHER_UNIT_MACROS_SVH
`define WILDCARD_NAME_MATCHER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define WNM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define WNM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wnm_pkg.sv
// shared constants, types and register codes of the wildcard name matcher
`timescale 1ns / 1ps

package wnm_pkg;

    // pattern limits
    localparam int PATTERN_MAX_DEF = 32;
    localparam int PAT_LEN_W       = 6;
    localparam int PAT_WORD_W      = 64;
    localparam int PAT_WORDS       = 4;
    localparam int PAT_FLAT_W      = PAT_WORD_W * PAT_WORDS;

    // special pattern bytes
    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QUERY_BYTE = 8'h3F;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    // configuration register codes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOB_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd5;

    // control flags from the pattern registers to the matcher
    typedef struct packed {
        logic glob_enable;
        logic rearm;
    } cfg_ctrl_t;

endpackage

FILE: src/wildcard_name_matcher_unit.sv
// top level of the wildcard name matcher: stream ports, nfa update and result register
`timescale 1ns / 1ps
`include "wildcard_name_matcher_unit_macros.svh"

// Glob matcher for names streamed one byte per word. '*' matches any run of bytes,
// '?' any single byte, anything else itself. A word with tlast set ends the name and
// produces one result word (bit 0 = matched); other words produce nothing. Throughput
// is one word per clock while results are taken; a word passes an input register and,
// for a terminator, a result register, which holds the result word once the terminator
// has left the input register. A terminator waits in the input register only while the
// previous result word has not been taken. The rate is set by the live-position
// update, whose longest path is one (PATTERN_MAX+1)-bit add that spreads liveness
// through runs of stars. Configuration is accepted in any cycle but must be written
// while no name byte is in flight; any write to a known register restarts the name.
// No clearing pass follows reset.
module wildcard_name_matcher_unit #(
    parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] name_byte
    input  logic                            s_tlast,   // is_terminator
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [0] matched, [7:1] zero
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wnm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wnm_pkg::cfg_ctrl_t             ctrl;
    logic [8*PATTERN_MAX-1:0]       pat_bytes;
    logic [PATTERN_MAX-1:0]         valid_mask;
    logic [PATTERN_MAX-1:0]         star_mask;
    logic [PATTERN_MAX-1:0]         query_mask;
    logic [PATTERN_MAX:0]           len_onehot;

    logic                           s1_valid_reg;
    logic [7:0]                     s1_byte_reg;
    logic                           s1_term_reg;
    logic                           m_valid_reg;
    logic                           m_match_reg;
    logic [PATTERN_MAX:0]           live_reg, live_next;

    logic                           out_free;
    logic                           s1_fire;
    logic [PATTERN_MAX-1:0]         eq_mask;
    logic [PATTERN_MAX-1:0]         adv_mask;
    logic [PATTERN_MAX:0]           star_ext;
    logic [PATTERN_MAX:0]           closed;
    logic                           match_now;

    assign cfg_ready = 1'b1;

    wnm_pattern #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_pattern (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctrl       (ctrl),
        .pat_bytes  (pat_bytes),
        .valid_mask (valid_mask),
        .star_mask  (star_mask),
        .query_mask (query_mask),
        .len_onehot (len_onehot)
    );

    // handshake: a terminator waits only while the result register is held
    assign out_free = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_term_reg || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;

    // literal compare of the current byte against every pattern position
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            eq_mask[i] = (pat_bytes[8*i +: 8] == s1_byte_reg);
        end
    end

    // star closure of the stored set: carry ripples through each run of stars
    assign star_ext = {1'b0, star_mask};
    assign closed   = live_reg | ((star_ext + (live_reg & star_ext)) ^ star_ext);

    // one nfa step: stars hold, matching positions advance by one
    assign adv_mask  = closed[PATTERN_MAX-1:0] & ~star_mask
                     & (query_mask | (valid_mask & eq_mask));
    assign live_next = (closed & star_ext) | {adv_mask, 1'b0};
    assign match_now = ctrl.glob_enable ? (|(closed & len_onehot)) : 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_byte_reg <= s_tdata;
            s1_term_reg <= s_tlast;
        end
    end

    // live position set, kept before star closure
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= (PATTERN_MAX+1)'(1);
        end
        else if (ctrl.rearm)
        begin
            live_reg <= (PATTERN_MAX+1)'(1);
        end
        else if (s1_fire)
        begin
            live_reg <= s1_term_reg ? (PATTERN_MAX+1)'(1) : live_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_term_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_term_reg)
        begin
            m_match_reg <= match_now;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_match_reg};

    // checks
    `WNM_ASSERT_NEXT(a_term_held, s1_valid_reg && s1_term_reg && !out_free,
        s1_valid_reg && s1_term_reg, "terminator dropped while result was blocked")
    `WNM_ASSERT_NEXT(a_no_glob_match, s1_fire && s1_term_reg && !ctrl.glob_enable,
        m_tvalid && m_tdata[0], "disabled glob gave a non-matching result")
    `WNM_ASSERT_NEXT(a_rearm_after_term, s1_fire && s1_term_reg && !ctrl.rearm,
        live_reg == (PATTERN_MAX+1)'(1), "live set not re-armed after terminator")
    `WNM_ASSERT_NEXT(a_no_spurious_result, out_free && !(s1_fire && s1_term_reg),
        !m_tvalid, "result appeared without a terminator")

endmodule

FILE: src/wnm_pattern.sv
// pattern registers and the per-position masks derived from them
`timescale 1ns / 1ps

module wnm_pattern #(
    parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wnm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wnm_pkg::cfg_ctrl_t              ctrl,
    output logic [8*PATTERN_MAX-1:0]        pat_bytes,
    output logic [PATTERN_MAX-1:0]          valid_mask,
    output logic [PATTERN_MAX-1:0]          star_mask,
    output logic [PATTERN_MAX-1:0]          query_mask,
    output logic [PATTERN_MAX:0]            len_onehot
);

    logic                               glob_enable_reg;
    logic [wnm_pkg::PAT_LEN_W-1:0]      pattern_length_reg;
    logic [wnm_pkg::PAT_WORD_W-1:0]     pattern_word_reg [wnm_pkg::PAT_WORDS];
    logic [wnm_pkg::PAT_FLAT_W-1:0]     pat_flat;
    logic [wnm_pkg::PAT_LEN_W-1:0]      lim;
    logic                               rearm;

    logic [PATTERN_MAX-1:0]             valid_reg, valid_next;
    logic [PATTERN_MAX-1:0]             star_reg, star_next;
    logic [PATTERN_MAX-1:0]             query_reg, query_next;
    logic [PATTERN_MAX:0]               onehot_reg, onehot_next;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glob_enable_reg    <= 1'b0;
            pattern_length_reg <= '0;
            for (int w = 0; w < wnm_pkg::PAT_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wnm_pkg::CFG_GLOB_ENABLE:    glob_enable_reg    <= cfg_data[0];
                wnm_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <=
                                                 cfg_data[wnm_pkg::PAT_LEN_W-1:0];
                wnm_pkg::CFG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_data;
                wnm_pkg::CFG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_data;
                wnm_pkg::CFG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_data;
                wnm_pkg::CFG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // any write to a known register restarts the name
    always_comb
    begin
        case (cfg_index) inside
            wnm_pkg::CFG_GLOB_ENABLE, wnm_pkg::CFG_PATTERN_LENGTH,
            wnm_pkg::CFG_PATTERN_WORD_0, wnm_pkg::CFG_PATTERN_WORD_1,
            wnm_pkg::CFG_PATTERN_WORD_2, wnm_pkg::CFG_PATTERN_WORD_3:
                rearm = cfg_we;
            default:
                rearm = 1'b0;
        endcase
    end

    assign pat_flat = {pattern_word_reg[3], pattern_word_reg[2],
                       pattern_word_reg[1], pattern_word_reg[0]};

    // length in use, saturated at the pattern maximum
    assign lim = (pattern_length_reg > wnm_pkg::PAT_LEN_W'(PATTERN_MAX))
               ? wnm_pkg::PAT_LEN_W'(PATTERN_MAX) : pattern_length_reg;

    // position masks: a position is in use below the limit and before the first nul
    always_comb
    begin
        logic [PATTERN_MAX-1:0] nz;
        logic [PATTERN_MAX-1:0] lo_mask;
        logic [7:0]             pb;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            nz[i] = (pat_flat[8*i +: 8] != wnm_pkg::NUL_BYTE);
        end
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pb            = pat_flat[8*i +: 8];
            lo_mask       = {PATTERN_MAX{1'b1}} >> (PATTERN_MAX - 1 - i);
            valid_next[i] = (lim > wnm_pkg::PAT_LEN_W'(i)) && (&(nz | ~lo_mask));
            star_next[i]  = valid_next[i] && (pb == wnm_pkg::STAR_BYTE);
            query_next[i] = valid_next[i] && (pb == wnm_pkg::QUERY_BYTE);
        end
        onehot_next[0] = !valid_next[0];
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            onehot_next[i] = valid_next[i-1] && !valid_next[i];
        end
        onehot_next[PATTERN_MAX] = valid_next[PATTERN_MAX-1];
    end

    // derived masks, registered in the cycle after the pattern registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            star_reg   <= '0;
            query_reg  <= '0;
            onehot_reg <= (PATTERN_MAX+1)'(1);
        end
        else
        begin
            valid_reg  <= valid_next;
            star_reg   <= star_next;
            query_reg  <= query_next;
            onehot_reg <= onehot_next;
        end
    end

    assign ctrl.glob_enable = glob_enable_reg;
    assign ctrl.rearm       = rearm;
    assign pat_bytes        = pat_flat[8*PATTERN_MAX-1:0];
    assign valid_mask       = valid_reg;
    assign star_mask        = star_reg;
    assign query_mask       = query_reg;
    assign len_onehot       = onehot_reg;

endmodule
